// File: rtl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared widths, register indexes and control words of the block FIR filter.
// ----------------------------------------------------------------------------
package fbc_pkg;

   localparam int TAPS_DEFAULT   = 6;
   localparam int SAMPLE_W       = 16;
   localparam int COEF_W         = 16;
   localparam int PROD_W         = 32;
   localparam int RESULT_W       = 34;
   localparam int TAP_COUNT_W    = 3;
   localparam int NUM_COEF_REGS  = 6;
   localparam int CSR_DATA_W     = 16;
   localparam int BYPASS_SHIFT   = 15;

   // Register map of the configuration port
   typedef enum logic [2:0] {
      CSR_ENABLE,
      CSR_TAP_COUNT,
      CSR_COEF_0,
      CSR_COEF_1,
      CSR_COEF_2,
      CSR_COEF_3,
      CSR_COEF_4,
      CSR_COEF_5
   } csr_index_type;

   // Control word broadcast to every cell of the delay line
   typedef struct packed {
      logic feed;    // shift the delay line by one sample
      logic clear;   // zero the delay line (end of block)
   } cell_ctrl_type;

   // Side information that travels beside the sum
   typedef struct packed {
      logic                       valid;
      logic                       last;
      logic                       bypass;
      logic signed [SAMPLE_W-1:0] sample;
   } meta_type;

   // One result word held in the output queue
   typedef struct packed {
      logic signed [RESULT_W-1:0] result;
      logic                       last;
   } rsp_word_type;

endpackage

// File: rtl/fbc_stream_if.sv
// ----------------------------------------------------------------------------
// fbc_req_if / fbc_rsp_if
// Valid/ready channels for sample words and result words.
// ----------------------------------------------------------------------------
interface fbc_req_if;
   import fbc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       block_end;

   modport source (output valid, output sample, output block_end, input ready);
   modport sink   (input valid, input sample, input block_end, output ready);
endinterface

interface fbc_rsp_if;
   import fbc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [RESULT_W-1:0] result;
   logic                       result_last;

   modport source (output valid, output result, output result_last, input ready);
   modport sink   (input valid, input result, input result_last, output ready);
endinterface

// File: rtl/fbc_cell.sv
// ----------------------------------------------------------------------------
// fbc_cell
// One tap: a delay-line stage and its registered coefficient product.
// ----------------------------------------------------------------------------
module fbc_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  fbc_pkg::cell_ctrl_type              ctrl_i,
   input  logic                                tap_on_i,
   input  logic signed [fbc_pkg::COEF_W-1:0]   coef_i,
   input  logic signed [fbc_pkg::SAMPLE_W-1:0] operand_i,
   output logic signed [fbc_pkg::SAMPLE_W-1:0] sample_o,
   output logic signed [fbc_pkg::PROD_W-1:0]   product_o
);
   import fbc_pkg::*;

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [PROD_W-1:0]   product_ff;
   logic signed [PROD_W-1:0]   product_in;

   // drop taps beyond the active count
   assign product_in = tap_on_i ? (PROD_W'(coef_i) * PROD_W'(operand_i)) : '0;

   always_ff @(posedge clock) begin
      if (reset || ctrl_i.clear) begin
         sample_ff <= '0;
      end else if (ctrl_i.feed) begin
         sample_ff <= operand_i;
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign sample_o  = sample_ff;
   assign product_o = product_ff;

endmodule

// File: rtl/fbc_adder_tree.sv
// ----------------------------------------------------------------------------
// fbc_adder_tree
// Pipelined binary adder tree, one register level per tree level.
// ----------------------------------------------------------------------------
module fbc_adder_tree #(
   parameter int LEAVES = fbc_pkg::TAPS_DEFAULT
) (
   input  logic                                clock,
   input  logic signed [fbc_pkg::PROD_W-1:0]   leaf_i [LEAVES],
   output logic signed [fbc_pkg::RESULT_W-1:0] root_o
);
   import fbc_pkg::*;

   localparam int LEVELS = $clog2(LEAVES);
   localparam int NPAD   = 1 << LEVELS;

   logic signed [RESULT_W-1:0] leaf_ext [NPAD];

   for (genvar g = 0; g < NPAD; g++) begin : g_leaf
      if (g < LEAVES) begin : g_used
         assign leaf_ext[g] = RESULT_W'(leaf_i[g]);
      end else begin : g_pad
         assign leaf_ext[g] = '0;
      end
   end

   if (LEVELS == 0) begin : g_single
      assign root_o = leaf_ext[0];
   end else begin : g_tree
      // heap order: node 1 is the root, children of node i are 2i and 2i+1
      logic signed [RESULT_W-1:0] node_ff [1:NPAD-1];

      for (genvar i = 1; i < NPAD; i++) begin : g_node
         if (2 * i >= NPAD) begin : g_bottom
            always_ff @(posedge clock) begin
               node_ff[i] <= leaf_ext[2*i-NPAD] + leaf_ext[2*i+1-NPAD];
            end
         end else begin : g_inner
            always_ff @(posedge clock) begin
               node_ff[i] <= node_ff[2*i] + node_ff[2*i+1];
            end
         end
      end

      assign root_o = node_ff[1];
   end

endmodule

// File: rtl/fir_block_convolution.sv
// ----------------------------------------------------------------------------
// fir_block_convolution
// Block FIR filter giving the full linear convolution of each sample block.
// ----------------------------------------------------------------------------
// Result path: the product registers load at the accept edge, then the
//   adder tree levels and the output queue write follow before the result
//   word is valid on rsp.
// Throughput: one word per cycle while rsp keeps up; a block end in filter
//   mode inserts (active tap count)-1 zero tail words during which req ready
//   stays low, and a stalled rsp drops req ready once DEPTH words are outstanding.
// Reset: synchronous, active high; clears the configuration registers, delay line and queue.
// ----------------------------------------------------------------------------
module fir_block_convolution #(
   parameter int TAPS = fbc_pkg::TAPS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   fbc_req_if.sink                               req_ch,
   fbc_rsp_if.source                             rsp_ch,
   input  logic                                  csr_we,
   input  fbc_pkg::csr_index_type                csr_index,
   input  logic [fbc_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import fbc_pkg::*;

   localparam int LEVELS = $clog2(TAPS);
   // pipeline stages between issue and queue write
   localparam int STAGES = LEVELS + 1;
   // queue deep enough for every word in flight plus slack for full rate
   localparam int DEPTH  = STAGES + 2;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int OCC_W  = $clog2(DEPTH + 1);
   // coefficient registers that have a tap behind them
   localparam int NCOEF  = (TAPS < NUM_COEF_REGS) ? TAPS : NUM_COEF_REGS;
   localparam int DLY_N  = (TAPS > 1) ? TAPS - 1 : 1;

   // -------------------------------------------------------------------------
   // Configuration registers
   // -------------------------------------------------------------------------
   logic                     enable_ff;
   logic [TAP_COUNT_W-1:0]   tap_count_ff;
   logic signed [COEF_W-1:0] coef_ff [NCOEF];
   logic [TAP_COUNT_W-1:0]   coef_sel;

   assign coef_sel = TAP_COUNT_W'(csr_index - CSR_COEF_0);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         tap_count_ff <= '0;
         for (int k = 0; k < NCOEF; k++) begin
            coef_ff[k] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index) inside
            CSR_ENABLE: begin
               enable_ff <= csr_wdata[0];
            end
            CSR_TAP_COUNT: begin
               tap_count_ff <= csr_wdata[TAP_COUNT_W-1:0];
            end
            [CSR_COEF_0:CSR_COEF_5]: begin
               // drop writes to coefficients that have no tap
               for (int k = 0; k < NCOEF; k++) begin
                  if (coef_sel == TAP_COUNT_W'(k)) begin
                     coef_ff[k] <= csr_wdata;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Saturate the tap count to the number of cells built
   logic [TAP_COUNT_W-1:0] taps_act;
   logic                   bypass;

   assign taps_act = (32'(tap_count_ff) > TAPS) ? TAP_COUNT_W'(TAPS) : tap_count_ff;
   assign bypass   = !enable_ff || (taps_act == '0);

   // -------------------------------------------------------------------------
   // Issue control: input words and tail feeds share one issue slot a cycle.
   // A slot is free while the words in flight and queued stay below DEPTH,
   // so the datapath never stalls; req ready drops during a block's tail and
   // once rsp has held back enough words to fill the queue.
   // -------------------------------------------------------------------------
   logic [TAP_COUNT_W-1:0]     tail_ff, tail_in;
   logic [OCC_W-1:0]           occ_ff, occ_in;
   logic                       slot_ok;
   logic                       in_tail;
   logic                       accept;
   logic                       issue;
   logic                       item_last;
   logic signed [SAMPLE_W-1:0] feed_sample;
   cell_ctrl_type              cell_ctrl;
   meta_type                   meta_in;

   assign slot_ok      = occ_ff < OCC_W'(DEPTH);
   assign in_tail      = tail_ff != '0;
   assign req_ch.ready = slot_ok && !in_tail;
   assign accept       = req_ch.valid && req_ch.ready;
   assign issue        = accept || (in_tail && slot_ok);

   always_comb begin
      cell_ctrl   = '0;
      feed_sample = '0;
      item_last   = 1'b0;
      tail_in     = tail_ff;
      if (in_tail) begin
         // feed a zero sample, close the block on the final tail word
         if (slot_ok) begin
            cell_ctrl.feed  = 1'b1;
            item_last       = (tail_ff == TAP_COUNT_W'(1));
            cell_ctrl.clear = item_last;
            tail_in         = tail_ff - TAP_COUNT_W'(1);
         end
      end else if (accept) begin
         feed_sample = req_ch.sample;
         if (bypass) begin
            // pass the sample by, keep the delay line unless the block ends
            item_last       = req_ch.block_end;
            cell_ctrl.clear = req_ch.block_end;
         end else begin
            cell_ctrl.feed = 1'b1;
            if (req_ch.block_end) begin
               if (taps_act == TAP_COUNT_W'(1)) begin
                  item_last       = 1'b1;
                  cell_ctrl.clear = 1'b1;
               end else begin
                  tail_in = taps_act - TAP_COUNT_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff <= '0;
      end else begin
         tail_ff <= tail_in;
      end
   end

   assign meta_in.valid  = issue;
   assign meta_in.last   = item_last;
   assign meta_in.bypass = !in_tail && bypass;
   assign meta_in.sample = feed_sample;

   // -------------------------------------------------------------------------
   // Cell chain: cell t holds the sample t steps back and multiplies the
   // sample it is handed by coefficient t.
   // -------------------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] dly [DLY_N];
   logic signed [PROD_W-1:0]   product [TAPS];

   for (genvar t = 0; t < TAPS; t++) begin : g_cell
      logic                       tap_on;
      logic signed [COEF_W-1:0]   coef;
      logic signed [SAMPLE_W-1:0] operand;

      assign tap_on = 32'(taps_act) > t;

      if (t < NCOEF) begin : g_coef
         assign coef = coef_ff[t];
      end else begin : g_nocoef
         assign coef = '0;
      end

      if (t == 0) begin : g_head
         assign operand = feed_sample;
      end else begin : g_body
         assign operand = dly[t-1];
      end

      if (t < TAPS - 1) begin : g_link
         fbc_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl_i    (cell_ctrl),
            .tap_on_i  (tap_on),
            .coef_i    (coef),
            .operand_i (operand),
            .sample_o  (dly[t]),
            .product_o (product[t])
         );
      end else begin : g_end
         fbc_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl_i    (cell_ctrl),
            .tap_on_i  (tap_on),
            .coef_i    (coef),
            .operand_i (operand),
            .sample_o  (),
            .product_o (product[t])
         );
      end
   end

   // Sum the products
   logic signed [RESULT_W-1:0] sum_root;

   fbc_adder_tree #(
      .LEAVES (TAPS)
   ) u_tree (
      .clock  (clock),
      .leaf_i (product),
      .root_o (sum_root)
   );

   // -------------------------------------------------------------------------
   // Side pipeline: advance valid, last and the bypass sample beside the sum
   // -------------------------------------------------------------------------
   meta_type meta_ff [STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) begin
            meta_ff[i] <= '0;
         end
      end else begin
         meta_ff[0] <= meta_in;
         for (int i = 1; i < STAGES; i++) begin
            meta_ff[i] <= meta_ff[i-1];
         end
      end
   end

   meta_type     done;
   rsp_word_type done_word;

   assign done             = meta_ff[STAGES-1];
   assign done_word.result = done.bypass ? (RESULT_W'(done.sample) <<< BYPASS_SHIFT) : sum_root;
   assign done_word.last   = done.last;

   // -------------------------------------------------------------------------
   // Output queue: hold finished words until rsp takes them
   // -------------------------------------------------------------------------
   rsp_word_type     fifo_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [OCC_W-1:0] fill_ff;
   logic             push;
   logic             pop;

   assign push = done.valid;
   assign pop  = rsp_ch.valid && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= done_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         fill_ff <= fill_ff + OCC_W'(push) - OCC_W'(pop);
      end
   end

   // Credits: words issued and not yet taken
   assign occ_in = occ_ff + OCC_W'(issue) - OCC_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign rsp_ch.valid       = fill_ff != '0;
   assign rsp_ch.result      = fifo_ff[rd_ptr_ff].result;
   assign rsp_ch.result_last = fifo_ff[rd_ptr_ff].last;

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Regression for fir_block_convolution. Sample words go in on req, result
// words come back on rsp. A scoreboard keeps its own copy of the kernel
// registers and the delay line. It queues the words that each accepted sample
// should produce, tail words included, and compares every returned word field
// by field in order. Settings change only while the filter is drained.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import fbc_pkg::*;

   localparam int TAPS          = TAPS_DEFAULT;
   localparam int SETTLE_CYCLES = 12;     // pipeline is clog2(TAPS)+2 deep
   localparam int RANDOM_ITEMS  = 420;

   // Receiver stall styles
   typedef enum int {SINK_OPEN, SINK_CADENCE, SINK_COIN, SINK_RUNS} sink_style_type;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow registers, shadow delay line, queue of due words
   // -------------------------------------------------------------------------
   class convolution_board;
      logic                       enable;
      logic [TAP_COUNT_W-1:0]     tap_count;
      logic signed [COEF_W-1:0]   coef [TAPS];
      logic signed [SAMPLE_W-1:0] window [TAPS];   // window[0] is the newest
      rsp_word_type               due_words [$];
      int                         errors;

      function new();
         enable    = 1'b0;
         tap_count = '0;
         foreach (coef[i]) coef[i] = '0;
         clear_window();
         errors = 0;
      endfunction

      function void clear_window();
         foreach (window[i]) window[i] = '0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         int k;
         case (idx)
            CSR_ENABLE:    enable    = data[0];
            CSR_TAP_COUNT: tap_count = data[TAP_COUNT_W-1:0];
            default: begin
               k = int'(idx) - int'(CSR_COEF_0);
               if (k >= 0 && k < TAPS) coef[k] = data;
            end
         endcase
      endfunction

      // Shift one sample into the window and return the kernel sum
      function logic signed [RESULT_W-1:0] shift_in(logic signed [SAMPLE_W-1:0] x,
                                                    int taps);
         longint acc;
         acc = 0;
         for (int t = TAPS - 1; t > 0; t--) window[t] = window[t-1];
         window[0] = x;
         for (int t = 0; t < taps; t++) acc += longint'(coef[t]) * longint'(window[t]);
         return acc[RESULT_W-1:0];
      endfunction

      function void absorb_sample(logic signed [SAMPLE_W-1:0] x, logic blk_end);
         int           taps;
         longint       wide;
         rsp_word_type w;
         taps = (tap_count > TAPS) ? TAPS : int'(tap_count);
         if (!enable || taps == 0) begin
            // bypass: the sample skips the delay line
            wide     = longint'(x) <<< BYPASS_SHIFT;
            w.result = wide[RESULT_W-1:0];
            w.last   = blk_end;
            due_words.push_back(w);
         end else begin
            w.result = shift_in(x, taps);
            w.last   = blk_end && taps == 1;
            due_words.push_back(w);
            if (blk_end) begin
               // tail: flush the window with zeros
               for (int k = 1; k < taps; k++) begin
                  w.result = shift_in('0, taps);
                  w.last   = (k == taps - 1);
                  due_words.push_back(w);
               end
            end
         end
         if (blk_end) clear_window();
      endfunction

      function void match_word(logic signed [RESULT_W-1:0] result, logic last);
         rsp_word_type w;
         if (due_words.size() == 0) begin
            $error("result word %0d arrived with nothing due", result);
            errors++;
            return;
         end
         w = due_words.pop_front();
         if (result !== w.result) begin
            $error("result: expected %0d, got %0d", w.result, result);
            errors++;
         end
         if (last !== w.last) begin
            $error("result_last: expected %0d, got %0d", w.last, last);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, buses, block
   // -------------------------------------------------------------------------
   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_we;
   csr_index_type           csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   fbc_req_if req_bus ();
   fbc_rsp_if rsp_bus ();

   convolution_board board;

   // sender pacing state
   int burst_left = 0;
   bit steady     = 1'b0;     // no gaps while set
   int sent       = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   fir_block_convolution #(.TAPS(TAPS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Driver tasks; each one is entered and left at a falling edge
   // -------------------------------------------------------------------------

   // Offer one sample word; gap between bursts unless pacing is steady
   task automatic push_sample(logic signed [SAMPLE_W-1:0] x, logic e);
      if (!steady) begin
         if (burst_left == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
      end
      req_bus.valid     <= 1'b1;
      req_bus.sample    <= x;
      req_bus.block_end <= e;
      do @(posedge clock); while (!req_bus.ready);
      board.absorb_sample(x, e);
      sent++;
      @(negedge clock);
   endtask

   // Drop valid and hold until every due word is back and the pipe is empty
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (board.due_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write one register; back-to-back writes keep the enable high
   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      board.write_reg(idx, data);
   endtask

   task automatic csr_done();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Write mode and tap count with junk in the unused upper bits
   task automatic set_mode(logic en, logic [TAP_COUNT_W-1:0] taps);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      csr_write(CSR_ENABLE, {junk[CSR_DATA_W-1:1], en});
      junk = CSR_DATA_W'($urandom);
      csr_write(CSR_TAP_COUNT, {junk[CSR_DATA_W-1:TAP_COUNT_W], taps});
   endtask

   // Random 16-bit value, biased toward both extremes
   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'($urandom_range(0, 15));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic set_all_coefs(logic [CSR_DATA_W-1:0] v, bit scatter);
      for (int k = 0; k < NUM_COEF_REGS; k++)
         csr_write(csr_index_type'(int'(CSR_COEF_0) + k), scatter ? pick16() : v);
   endtask

   // -------------------------------------------------------------------------
   // Result side: stall on a pattern of its own, check at the rising edge
   // -------------------------------------------------------------------------
   initial begin : sink_side
      sink_style_type style;
      int             cycle;
      int             run;
      logic           run_level;
      logic           level;
      style     = SINK_OPEN;
      cycle     = 0;
      run       = 0;
      run_level = 1'b1;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         cycle++;
         // switch style now and then; open stretches come up too
         if (cycle % 160 == 0) style = sink_style_type'($urandom_range(0, 3));
         case (style)
            SINK_OPEN:    level = 1'b1;
            SINK_CADENCE: level = (cycle % 4 != 3);
            SINK_COIN:    level = ($urandom_range(0, 9) < 6);
            default: begin
               if (run == 0) begin
                  run_level = !run_level;
                  run       = $urandom_range(1, 8);
               end
               run--;
               level = run_level;
            end
         endcase
         rsp_bus.ready <= level;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.match_word(rsp_bus.result, rsp_bus.result_last);
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : source_side
      int target;
      int nblocks;
      int len;
      bit open_end;
      logic e;

      board = new();
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.sample    = '0;
      req_bus.block_end = 1'b0;
      csr_we            = 1'b0;
      csr_index         = CSR_ENABLE;
      csr_wdata         = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // bypass straight out of reset
      push_sample(16'h8000, 1'b0);
      push_sample(16'h7FFF, 1'b0);
      push_sample(16'h0000, 1'b1);
      push_sample(16'hFFFF, 1'b1);
      settle();

      // all taps at the negative extreme: the largest positive sums
      set_mode(1'b1, 3'd6);
      set_all_coefs(16'h8000, 1'b0);
      csr_done();
      push_sample(16'h8000, 1'b0);
      push_sample(16'h8000, 1'b0);
      push_sample(16'h8000, 1'b1);
      settle();

      // positive extreme kernel against mixed extreme samples
      set_all_coefs(16'h7FFF, 1'b0);
      csr_done();
      push_sample(16'h8000, 1'b0);
      push_sample(16'h7FFF, 1'b1);
      settle();

      // tap count above TAPS saturates
      set_mode(1'b1, 3'd7);
      set_all_coefs('0, 1'b1);
      csr_done();
      repeat (3) push_sample(pick16(), 1'b0);
      push_sample(pick16(), 1'b1);
      settle();

      // single tap: no tail, last rides on the sample's own word
      set_mode(1'b1, 3'd1);
      csr_done();
      push_sample(pick16(), 1'b0);
      push_sample(pick16(), 1'b1);
      settle();

      // enabled with zero taps is bypass
      set_mode(1'b1, 3'd0);
      csr_done();
      push_sample(pick16(), 1'b0);
      push_sample(pick16(), 1'b1);
      settle();

      // change mode in the middle of a block; held samples must survive
      set_mode(1'b1, 3'd3);
      csr_done();
      push_sample(pick16(), 1'b0);
      push_sample(pick16(), 1'b0);
      settle();
      set_mode(1'b0, 3'd3);
      csr_done();
      push_sample(pick16(), 1'b0);
      settle();
      set_mode(1'b1, 3'd5);
      csr_done();
      push_sample(pick16(), 1'b0);
      push_sample(pick16(), 1'b1);
      settle();

      // block end during bypass still clears the delay line
      set_mode(1'b1, 3'd4);
      csr_done();
      push_sample(pick16(), 1'b0);
      settle();
      set_mode(1'b0, 3'd4);
      csr_done();
      push_sample(pick16(), 1'b1);
      settle();
      set_mode(1'b1, 3'd4);
      csr_done();
      push_sample(pick16(), 1'b0);
      push_sample(pick16(), 1'b1);

      // random phases: new settings, then a run of blocks
      target = sent + RANDOM_ITEMS;
      while (sent < target) begin
         settle();
         set_mode($urandom_range(0, 9) != 0, 3'($urandom_range(0, 7)));
         for (int k = 0; k < NUM_COEF_REGS; k++)
            if ($urandom_range(0, 2) != 0)
               csr_write(csr_index_type'(int'(CSR_COEF_0) + k), pick16());
         csr_done();
         steady   = ($urandom_range(0, 3) == 0);
         nblocks  = $urandom_range(1, 5);
         // leave some phases open so the next setting lands mid-block
         open_end = ($urandom_range(0, 4) == 0);
         for (int b = 0; b < nblocks; b++) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
               e = (i == len - 1) && !(open_end && b == nblocks - 1);
               push_sample(pick16(), e);
            end
         end
      end

      settle();
      if (board.errors == 0 && board.due_words.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog far beyond the slowest legal run
   initial begin
      #(2_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: fir_block_convolution.f
rtl/fbc_pkg.sv
rtl/fbc_stream_if.sv
rtl/fbc_cell.sv
rtl/fbc_adder_tree.sv
rtl/fir_block_convolution.sv
tb/sv/testbench.sv
